/* src/lvct_pkg.sv */
`timescale 1ns / 1ps

package lvct_pkg;

  localparam int INDEX_BITS_DEF = 10;
  localparam int ADDR_W         = 64;
  localparam int IN_DATA_W      = 72;
  localparam int OUT_DATA_W     = 8;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  localparam logic [1:0] SCHEME_ONE_BIT = 2'd1;
  localparam logic [1:0] SCHEME_TWO_BIT = 2'd2;
  localparam logic [1:0] SCHEME_RESET   = SCHEME_TWO_BIT;

  typedef enum logic [1:0] {
    CLS_NP1   = 2'd0,
    CLS_NP2   = 2'd1,
    CLS_PRED  = 2'd2,
    CLS_CONST = 2'd3
  } cls_t;

  typedef struct packed {
    logic valid;
    cls_t cls;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP
  } state_t;

endpackage

/* src/lvct_ram.sv */
`timescale 1ns / 1ps

module lvct_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/load_value_classification_table.sv */
`timescale 1ns / 1ps

// Load classification table for load value prediction.
// Input stream: tuser carries the mode (lookup or update), tdata carries the
// load address and the prediction outcome. Each accepted transaction gives
// one result transaction on the output stream: predict and is_constant for a
// lookup, became_constant and left_constant for an update.
// The table sits in one synchronous RAM, one 3-bit entry (valid, class) per
// index; an update reads the entry, steps its class and writes it back.
// The entry read is registered in the RAM, and the result after it in the output
// register. A new transaction is not accepted until the last has left ST_RESP,
// as the RAM read and its write-back share the single table. After reset
// the block sweeps the RAM, one entry a cycle, through all 2**INDEX_BITS
// entries (1024 by default) with s_axis_tready low; cfg writes are taken then.
// The result waits in an output register; while the receiver stalls a new
// transaction is still accepted and read, and holds until the register frees.
// cfg_data selects the one-bit (1) or two-bit (2) scheme; reset value is 2.

module load_value_classification_table
  import lvct_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [63:0] address, [64] prediction_correct, [71:65] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] mode
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] predict, [1] is_constant, [2] became_constant, [3] left_constant, [7:4] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_data
);

  localparam int DEPTH = 1 << INDEX_BITS;

  state_t                state;
  state_t                state_next;
  logic [1:0]            counter_bits;
  logic [INDEX_BITS-1:0] clear_addr;
  logic                  item_mode;
  logic                  item_correct;
  logic [INDEX_BITS-1:0] item_index;
  logic                  out_valid;
  logic [3:0]            out_flags;
  logic [3:0]            out_flags_next;
  logic                  out_load;

  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic                  mem_re;
  logic [ENTRY_W-1:0]    mem_rdata;
  entry_t                rd_entry;
  entry_t                wr_entry;
  cls_t                  cls_next;
  logic                  became;
  logic                  left;

  lvct_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(s_axis_tdata[INDEX_BITS+1:2]),
    .rdata(mem_rdata)
  );

  assign rd_entry      = entry_t'(mem_rdata);
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-4){1'b0}}, out_flags};

  always_comb begin
    cls_next = rd_entry.cls;
    became   = 1'b0;
    left     = 1'b0;
    case (counter_bits)
      SCHEME_ONE_BIT: begin
        if (item_correct) begin
          if (rd_entry.cls == CLS_NP1) begin
            cls_next = CLS_CONST;
            became   = 1'b1;
          end
        end else if (rd_entry.cls == CLS_CONST) begin
          cls_next = CLS_NP1;
          left     = 1'b1;
        end
      end
      SCHEME_TWO_BIT: begin
        if (item_correct) begin
          case (rd_entry.cls)
            CLS_NP1:  cls_next = CLS_NP2;
            CLS_NP2:  cls_next = CLS_PRED;
            CLS_PRED: begin
              cls_next = CLS_CONST;
              became   = 1'b1;
            end
            default:  cls_next = rd_entry.cls;
          endcase
        end else begin
          case (rd_entry.cls)
            CLS_NP2:   cls_next = CLS_NP1;
            CLS_PRED:  cls_next = CLS_NP2;
            CLS_CONST: begin
              cls_next = CLS_PRED;
              left     = 1'b1;
            end
            default:   cls_next = rd_entry.cls;
          endcase
        end
      end
      default: cls_next = CLS_NP1;
    endcase
  end

  always_comb begin
    wr_entry.valid = 1'b1;
    wr_entry.cls   = cls_next;
    if (item_mode == MODE_UPDATE) begin
      out_flags_next = {left, became, 2'b00};
    end else begin
      out_flags_next = {2'b00,
                        rd_entry.valid && (rd_entry.cls == CLS_CONST),
                        rd_entry.valid && ((rd_entry.cls == CLS_PRED) ||
                                           (rd_entry.cls == CLS_CONST))};
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = item_index;
    mem_wdata  = wr_entry;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_addr;
        mem_wdata = '0;
        if (clear_addr == {INDEX_BITS{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mem_re     = 1'b1;
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          mem_we     = (item_mode == MODE_UPDATE);
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clear_addr   <= '0;
      counter_bits <= SCHEME_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (cfg_valid) begin
        counter_bits <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      item_mode    <= s_axis_tuser;
      item_correct <= s_axis_tdata[ADDR_W];
      item_index   <= s_axis_tdata[INDEX_BITS+1:2];
    end
    if (out_load) begin
      out_flags <= out_flags_next;
    end
  end

endmodule
